### hdl/srca_pkg.sv
// Shared types and constants of the search result cache with aging.
// Entry layout, request and result bundles, request and bound codes.
// No dependencies.
package srca_pkg;

    localparam int INDEX_BITS = 16;
    localparam int ENTRY_COUNT = 1 << INDEX_BITS;
    localparam int KEY_BITS = 64;
    localparam int TAG_LSB = 32;
    localparam int TAG_BITS = 32;
    localparam int ADDR_BITS = 3;

    typedef enum logic [0:0] {
        KIND_PROBE = 1'b0,
        KIND_STORE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        BND_NONE  = 2'd0,
        BND_UPPER = 2'd1,
        BND_LOWER = 2'd2,
        BND_EXACT = 2'd3
    } bound_t;

    // Word index of the search age register on the configuration port.
    localparam logic [0:0] REG_SEARCH_AGE = 1'b0;

    // One stored entry, most significant field first.
    typedef struct packed {
        logic [15:0]        move;
        logic [7:0]         age;
        logic [1:0]         bound;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef struct packed {
        logic               kind;
        logic [TAG_BITS-1:0] tag;
        logic signed [7:0]  depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [15:0]        move;
    } request_t;

    typedef struct packed {
        logic               tag_hit;
        logic               cutoff;
        logic signed [15:0] score;
        logic [15:0]        move;
    } result_t;

endpackage

### hdl/srca_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/srca_regs.sv
// APB-style configuration register block holding the search age.
// Depends on srca_pkg.
module srca_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srca_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output logic [7:0]                     search_age
);

    logic [7:0] search_age_reg;
    logic [7:0] search_age_next;
    logic       sel_age;

    assign pready  = 1'b1;
    assign sel_age = (paddr[2] == srca_pkg::REG_SEARCH_AGE);

    always_comb
    begin
        search_age_next = search_age_reg;
        if (psel && penable && pwrite && sel_age)
        begin
            search_age_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_age_reg <= 8'd0;
        end
        else
        begin
            search_age_reg <= search_age_next;
        end
    end

    assign prdata     = sel_age ? {24'd0, search_age_reg} : 32'd0;
    assign search_age = search_age_reg;

endmodule

### hdl/srca_eval.sv
// Probe and store decision logic: tag compare, cutoff test, replacement
// rule and the merged entry to write back. Depends on srca_pkg.
module srca_eval (
    input  srca_pkg::request_t                  req,
    input  logic [srca_pkg::TAG_BITS-1:0]       stored_tag,
    input  srca_pkg::entry_t                    stored,
    input  logic [7:0]                          search_age,
    output srca_pkg::result_t                   result,
    output logic                                write_en,
    output srca_pkg::entry_t                    new_entry
);

    logic hit;
    logic depth_ok;
    logic bound_ok;
    logic is_store;

    always_comb
    begin
        hit      = (stored_tag == req.tag);
        is_store = (req.kind == srca_pkg::KIND_STORE);
        depth_ok = ($signed(stored.depth) >= $signed(req.depth));

        case (srca_pkg::bound_t'(stored.bound))
            srca_pkg::BND_EXACT: bound_ok = 1'b1;
            srca_pkg::BND_UPPER: bound_ok = ($signed(stored.score) <= $signed(req.alpha));
            srca_pkg::BND_LOWER: bound_ok = ($signed(stored.score) >= $signed(req.beta));
            default:             bound_ok = 1'b0;
        endcase

        // Stores always report an all-zero result; a probe miss does too.
        result.tag_hit = !is_store && hit;
        result.cutoff  = !is_store && hit && depth_ok && bound_ok;
        result.score   = result.tag_hit ? stored.score : 16'sd0;
        result.move    = result.tag_hit ? stored.move : 16'd0;

        write_en = is_store && (hit || (stored.age != search_age)
                   || ($signed(req.depth) >= $signed(stored.depth)));

        new_entry.score = req.score;
        new_entry.depth = req.depth;
        new_entry.bound = req.bound;
        new_entry.age   = search_age;
        new_entry.move  = (hit && (req.move == 16'd0)) ? stored.move : req.move;
    end

endmodule

### hdl/search_result_cache_with_aging.sv
// Top level of the search result cache with aging: request sequencer,
// tag and entry memories, configuration port. Depends on srca_pkg,
// srca_ram, srca_regs and srca_eval.
//
//   channel  | direction | handshake              | beat carries
//   ---------+-----------+------------------------+-------------------------------
//   request  | in        | req_valid / req_stall  | kind, position_key, depth, ...
//   response | out       | rsp_valid / rsp_stall  | tag_hit, cutoff, found_*
//   config   | in        | APB psel/penable/pready| search_age at word 0
//
// Each request passes through the idle state, which issues the
// synchronous read of both memories on accept, and then the lookup state,
// which does the compare, the write back and the load of the response
// register. The memory read latency and the read-modify-write of a single
// entry set this sequence. After reset a clearing pass writes zeros to
// every entry (2^INDEX_BITS of them, 65536 at the default size), one per
// cycle; req_stall is high during the pass, while configuration writes are
// taken as usual. A stalled response holds the request in the compare state
// until the response register frees up.
module search_result_cache_with_aging (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           kind,
    input  logic [63:0]                    position_key,
    input  logic signed [7:0]              search_depth,
    input  logic signed [15:0]             alpha,
    input  logic signed [15:0]             beta,
    input  logic signed [15:0]             score,
    input  logic [1:0]                     bound_kind,
    input  logic [15:0]                    best_move,

    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic                           tag_hit,
    output logic                           cutoff,
    output logic signed [15:0]             found_score,
    output logic [15:0]                    found_move,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [srca_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [srca_pkg::INDEX_BITS-1:0]  clr_addr_reg;
    logic [srca_pkg::INDEX_BITS-1:0]  clr_addr_next;
    logic [srca_pkg::INDEX_BITS-1:0]  idx_reg;
    logic [srca_pkg::INDEX_BITS-1:0]  idx_next;
    srca_pkg::request_t               req_reg;
    srca_pkg::request_t               req_next;
    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    srca_pkg::result_t                rsp_reg;
    srca_pkg::result_t                rsp_next;

    logic                             req_accept;
    logic                             rsp_free;
    logic                             finish;
    logic [7:0]                       search_age;

    logic                             ram_we;
    logic [srca_pkg::INDEX_BITS-1:0]  ram_waddr;
    logic [srca_pkg::TAG_BITS-1:0]    tag_wdata;
    srca_pkg::entry_t                 entry_wdata;
    logic [srca_pkg::TAG_BITS-1:0]    tag_rdata;
    logic [srca_pkg::ENTRY_BITS-1:0]  entry_rdata;

    srca_pkg::result_t                eval_result;
    logic                             eval_we;
    srca_pkg::entry_t                 eval_entry;

    // Configuration register.
    srca_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .search_age (search_age)
    );

    // Only the idle state takes a request; the response register decouples
    // the result from the downstream stall.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign finish     = (state_reg == ST_LOOKUP) && rsp_free;

    // Tag and entry memories share the index; both are read on accept and
    // written either by the clearing pass or by a store that wins.
    srca_ram #(
        .WIDTH (srca_pkg::TAG_BITS),
        .DEPTH (srca_pkg::ENTRY_COUNT)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tag_wdata),
        .re    (req_accept),
        .raddr (position_key[srca_pkg::INDEX_BITS-1:0]),
        .rdata (tag_rdata)
    );

    srca_ram #(
        .WIDTH (srca_pkg::ENTRY_BITS),
        .DEPTH (srca_pkg::ENTRY_COUNT)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (entry_wdata),
        .re    (req_accept),
        .raddr (position_key[srca_pkg::INDEX_BITS-1:0]),
        .rdata (entry_rdata)
    );

    // Hit, cutoff and replacement decision on the read data.
    srca_eval u_eval (
        .req        (req_reg),
        .stored_tag (tag_rdata),
        .stored     (srca_pkg::entry_t'(entry_rdata)),
        .search_age (search_age),
        .result     (eval_result),
        .write_en   (eval_we),
        .new_entry  (eval_entry)
    );

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_reg;
            tag_wdata   = '0;
            entry_wdata = '0;
        end
        else
        begin
            ram_we      = finish && eval_we;
            ram_waddr   = idx_reg;
            tag_wdata   = req_reg.tag;
            entry_wdata = eval_entry;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    idx_next       = position_key[srca_pkg::INDEX_BITS-1:0];
                    req_next.kind  = kind;
                    req_next.tag   = position_key[srca_pkg::KEY_BITS-1:srca_pkg::TAG_LSB];
                    req_next.depth = search_depth;
                    req_next.alpha = alpha;
                    req_next.beta  = beta;
                    req_next.score = score;
                    req_next.bound = bound_kind;
                    req_next.move  = best_move;
                    state_next     = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (finish)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = eval_result;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign tag_hit     = rsp_reg.tag_hit;
    assign cutoff      = rsp_reg.cutoff;
    assign found_score = rsp_reg.score;
    assign found_move  = rsp_reg.move;

    // No response may appear while the memories are still being cleared.
    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !rsp_valid_reg)
        else $error("response valid during clearing pass");

    // Only one request is in flight: an accept closes the request side.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> req_stall)
        else $error("request accepted while another is in flight");

    // A memory write outside the clearing pass comes from a store only.
    a_write_is_store: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg != ST_CLEAR)) |-> (req_reg.kind == srca_pkg::KIND_STORE))
        else $error("memory written by a probe");

    // A store always answers with an all-zero response.
    a_store_rsp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (req_reg.kind == srca_pkg::KIND_STORE))
        |=> (rsp_valid && !tag_hit && !cutoff && (found_score == 16'sd0)
             && (found_move == 16'd0)))
        else $error("store returned a nonzero response");

endmodule

### tb/search_result_cache_with_aging_tb.sv
// Self-checking testbench for the search result cache with aging.
// Drives probe and store beats plus search_age writes and predicts every response beat.
// Depends on srca_pkg and search_result_cache_with_aging.
module search_result_cache_with_aging_tb;

    // Run shape. The hold-off is long enough to fill every stage of the block.
    localparam int RANDOM_PHASE_ITEMS = 250;
    localparam int HOLD_CYCLES        = 300;
    localparam int PRESSURE_ITEMS     = 48;
    localparam int DRAIN_LIMIT        = 20000;
    localparam int SETTLE_CYCLES      = 8;
    localparam int HOT_SLOTS          = 16;
    localparam int HOT_TAGS           = 4;

    // search_age is register 0, so it sits at byte address 0.
    localparam logic [srca_pkg::ADDR_BITS-1:0] AGE_ADDR = {srca_pkg::REG_SEARCH_AGE, 2'b00};

    typedef logic [srca_pkg::INDEX_BITS-1:0] slot_t;
    typedef logic [srca_pkg::TAG_BITS-1:0]   tag_t;

    // One request beat as the testbench sees it: the full key, not just the tag.
    typedef struct packed {
        srca_pkg::kind_t    op;
        logic [63:0]        key;
        logic signed [7:0]  depth;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic signed [15:0] score;
        srca_pkg::bound_t   bound;
        logic [15:0]        move;
    } cache_req_t;

    // Every input starts at a known value. Reset is held from time zero.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    logic                   kind = 1'b0;
    logic [63:0]            position_key = '0;
    logic signed [7:0]      search_depth = '0;
    logic signed [15:0]     alpha = '0;
    logic signed [15:0]     beta = '0;
    logic signed [15:0]     score = '0;
    logic [1:0]             bound_kind = '0;
    logic [15:0]            best_move = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    logic                   tag_hit;
    logic                   cutoff;
    logic signed [15:0]     found_score;
    logic [15:0]            found_move;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [srca_pkg::ADDR_BITS-1:0] paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Shadow copy of both memories and of the age register.
    tag_t                   shadow_tag [srca_pkg::ENTRY_COUNT];
    srca_pkg::entry_t       shadow_entry [srca_pkg::ENTRY_COUNT];
    logic [7:0]             shadow_age = '0;

    // Responses that are owed, oldest first.
    srca_pkg::result_t      predicted_replies [$];

    // Slots and tags that the random traffic keeps coming back to, so that
    // probes hit stored entries and stores compete for the same slot.
    slot_t                  hot_index [HOT_SLOTS];
    tag_t                   hot_tag [HOT_TAGS];

    int unsigned            send_idle_pct = 0;
    int unsigned            recv_idle_pct = 0;
    logic                   hold_on = 1'b0;
    event                   hold_go;

    int                     fail_count = 0;
    int                     probe_count = 0;
    int                     store_count = 0;
    int                     hit_count = 0;
    int                     cutoff_count = 0;
    int                     age_writes = 0;

    search_result_cache_with_aging uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .position_key (position_key),
        .search_depth (search_depth),
        .alpha        (alpha),
        .beta         (beta),
        .score        (score),
        .bound_kind   (bound_kind),
        .best_move    (best_move),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .tag_hit      (tag_hit),
        .cutoff       (cutoff),
        .found_score  (found_score),
        .found_move   (found_move),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Receiver side. It stalls at random at the current rate, and holds the
    // stall high throughout a hold-off.
    always @(posedge clk)
    begin
        rsp_stall <= hold_on || ($urandom_range(99) < recv_idle_pct);
    end

    // The hold-off counts its own cycles, so the sender keeps offering beats
    // while the block backs up.
    always
    begin
        @(hold_go);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
    end

    // Model of one request: returns the response the block owes for it and
    // applies the write back that a store earns. Probes never change state.
    function automatic srca_pkg::result_t cache_lookup_update(cache_req_t r);
        slot_t                 idx;
        tag_t                  tag;
        srca_pkg::entry_t      ent;
        logic                  hit;
        srca_pkg::result_t     res;
        idx = r.key[srca_pkg::INDEX_BITS-1:0];
        tag = r.key[srca_pkg::TAG_LSB +: srca_pkg::TAG_BITS];
        ent = shadow_entry[idx];
        hit = (shadow_tag[idx] == tag);
        res = '0;
        if (r.op == srca_pkg::KIND_PROBE)
        begin
            probe_count++;
            if (hit)
            begin
                hit_count++;
                res.tag_hit = 1'b1;
                res.score = ent.score;
                res.move = ent.move;
                // The stored result must be at least as deep as asked, and
                // its bound must settle the window.
                if (ent.depth >= r.depth)
                begin
                    case (srca_pkg::bound_t'(ent.bound))
                        srca_pkg::BND_EXACT: res.cutoff = 1'b1;
                        srca_pkg::BND_UPPER: res.cutoff = (ent.score <= r.alpha);
                        srca_pkg::BND_LOWER: res.cutoff = (ent.score >= r.beta);
                        default:             res.cutoff = 1'b0;
                    endcase
                end
                if (res.cutoff)
                    cutoff_count++;
            end
        end
        else
        begin
            store_count++;
            // Replace on a matching tag, on an entry from another search, or
            // when the new result is at least as deep as the old one.
            if (hit || ent.age != shadow_age || r.depth >= ent.depth)
            begin
                // A null move on a same-position update keeps the old move.
                if (!(hit && r.move == '0))
                    ent.move = r.move;
                ent.score = r.score;
                ent.depth = r.depth;
                ent.bound = r.bound;
                ent.age = shadow_age;
                shadow_tag[idx] = tag;
                shadow_entry[idx] = ent;
            end
        end
        return res;
    endfunction

    function automatic cache_req_t make_req(srca_pkg::kind_t op, logic [63:0] key, int depth,
                                            int lo, int hi, int sc, srca_pkg::bound_t bound,
                                            logic [15:0] move);
        cache_req_t r;
        r.op = op;
        r.key = key;
        r.depth = 8'(depth);
        r.alpha = 16'(lo);
        r.beta = 16'(hi);
        r.score = 16'(sc);
        r.bound = bound;
        r.move = move;
        return r;
    endfunction

    // Random request. Most keys land on a few hot slots with a few hot tags;
    // depths are mostly small, and scores and windows small half the time, so
    // that bounds and depth tests go both ways, with full-range values mixed in.
    function automatic cache_req_t random_req();
        cache_req_t            r;
        slot_t                 idx;
        tag_t                  tag;
        idx = ($urandom_range(99) < 85) ? hot_index[$urandom_range(HOT_SLOTS - 1)]
                                        : slot_t'($urandom);
        tag = ($urandom_range(99) < 80) ? hot_tag[$urandom_range(HOT_TAGS - 1)] : $urandom;
        r.op = srca_pkg::kind_t'($urandom_range(1));
        r.key = {tag, 32'($urandom)};
        r.key[srca_pkg::INDEX_BITS-1:0] = idx;
        r.depth = ($urandom_range(99) < 70) ? 8'($urandom_range(12)) : 8'($urandom);
        r.score = ($urandom_range(99) < 50) ? 16'(int'($urandom_range(16)) - 8)
                                            : 16'($urandom);
        r.alpha = ($urandom_range(99) < 50) ? 16'(int'($urandom_range(16)) - 8)
                                            : 16'($urandom);
        r.beta = ($urandom_range(99) < 50) ? 16'(int'($urandom_range(16)) - 8)
                                           : 16'($urandom);
        r.bound = srca_pkg::bound_t'($urandom_range(3));
        r.move = ($urandom_range(99) < 20) ? 16'h0000 : 16'($urandom);
        return r;
    endfunction

    // Offers one request beat and returns once it is taken. Called at a
    // rising edge; valid stays high into the next call unless that call idles.
    task automatic send_item(input cache_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= r.op;
        position_key <= r.key;
        search_depth <= r.depth;
        alpha <= r.alpha;
        beta <= r.beta;
        score <= r.score;
        bound_kind <= r.bound;
        best_move <= r.move;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted_replies.push_back(cache_lookup_update(r));
    endtask

    // Stops offering beats and waits until every owed response has come
    // back, then lets the block settle.
    task automatic drain_replies();
        int waited;
        waited = 0;
        req_valid <= 1'b0;
        while (predicted_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes search_age with a setup and an access cycle, then reads it back.
    task automatic program_search_age(input logic [7:0] age);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AGE_ADDR;
        pwdata <= 32'(age);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        shadow_age = age;
        age_writes++;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== age)
        begin
            $error("search_age mismatch: expected %0d, actual %0d", age, prdata[7:0]);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // After the clearing pass every slot holds tag zero with empty fields:
    // a key with zero upper bits hits and reads zeros without a cutoff, any
    // other tag misses.
    task automatic test_empty_entries();
        program_search_age(8'd0);
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_0000_0000_0000, -128, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_0000_FFFF_FFFF, 127, 32767,
                           -32768, 0, srca_pkg::BND_EXACT, 16'hFFFF));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, -128, -32768,
                           32767, -1, srca_pkg::BND_UPPER, 16'h0001));
    endtask

    // Each bound kind with and without a cutoff, the depth test, the null
    // move on a same-tag update, and a shallower store that is turned away.
    task automatic test_bounds_and_replacement();
        send_item(make_req(srca_pkg::KIND_STORE, 64'h1234_5678_0000_0005, 5, 0, 0, 32767,
                           srca_pkg::BND_EXACT, 16'hFFFF));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h1234_5678_0000_0005, 5, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h1234_5678_0000_0005, 6, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_STORE, 64'h1234_5678_0000_0005, 3, 0, 0, -32768,
                           srca_pkg::BND_UPPER, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h1234_5678_0000_0005, 3, -32768, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_STORE, 64'hFFFF_FFFF_ABCD_0009, 127, 0, 0, 100,
                           srca_pkg::BND_LOWER, 16'h0001));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'hFFFF_FFFF_ABCD_0009, 127, 0, 100, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'hFFFF_FFFF_ABCD_0009, 127, 0, 101, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        // Different tag, same age, shallower: the slot keeps its entry.
        send_item(make_req(srca_pkg::KIND_STORE, 64'h0000_0001_5555_0009, 126, 0, 0, 9,
                           srca_pkg::BND_EXACT, 16'h1234));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_0001_5555_0009, -128, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'hFFFF_FFFF_ABCD_0009, -128, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_STORE, 64'h0000_A5A5_0000_0010, 0, 0, 0, 7,
                           srca_pkg::BND_UPPER, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_A5A5_0000_0010, 0, 6, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_A5A5_0000_0010, -1, 7, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        // An entry without a bound never allows a cutoff.
        send_item(make_req(srca_pkg::KIND_STORE, 64'h1234_5678_0000_0005, 10, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h8000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h1234_5678_0000_0005, -128, 32767,
                           -32768, 0, srca_pkg::BND_NONE, 16'h0000));
        drain_replies();
    endtask

    // Once the search age moves on, any store takes over an old slot, even
    // the shallowest one.
    task automatic test_age_change();
        program_search_age(8'd7);
        send_item(make_req(srca_pkg::KIND_STORE, 64'h0000_0001_5555_0009, -128, 0, 0, -1,
                           srca_pkg::BND_EXACT, 16'hBEEF));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'h0000_0001_5555_0009, -128, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        send_item(make_req(srca_pkg::KIND_PROBE, 64'hFFFF_FFFF_ABCD_0009, -128, 0, 0, 0,
                           srca_pkg::BND_NONE, 16'h0000));
        drain_replies();
    endtask

    // One phase of random traffic under a given age and idling mix.
    task automatic test_random_traffic(input logic [7:0] age, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        drain_replies();
        program_search_age(age);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_PHASE_ITEMS)
            send_item(random_req());
    endtask

    // The receiver stops for a long stretch while requests keep coming, so
    // the block has to stall its input and then catch up.
    task automatic test_backpressure();
        drain_replies();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> hold_go;
        repeat (PRESSURE_ITEMS)
            send_item(random_req());
        drain_replies();
    endtask

    // Response checker. Every accepted beat is matched against the oldest
    // owed response, field by field.
    always @(posedge clk)
    begin
        srca_pkg::result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (predicted_replies.size() == 0)
            begin
                $error("response beat with none owed: tag_hit %0b, cutoff %0b", tag_hit,
                       cutoff);
                fail_count++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (tag_hit !== want.tag_hit)
                begin
                    $error("tag_hit mismatch: expected %0b, actual %0b", want.tag_hit, tag_hit);
                    fail_count++;
                end
                if (cutoff !== want.cutoff)
                begin
                    $error("cutoff mismatch: expected %0b, actual %0b", want.cutoff, cutoff);
                    fail_count++;
                end
                if (found_score !== want.score)
                begin
                    $error("found_score mismatch: expected %0d, actual %0d", want.score,
                           found_score);
                    fail_count++;
                end
                if (found_move !== want.move)
                begin
                    $error("found_move mismatch: expected %0h, actual %0h", want.move,
                           found_move);
                    fail_count++;
                end
            end
        end
    end

    // Sequence of tests. The block clears its memories after reset with
    // req_stall high; the first request simply waits for that to finish.
    initial
    begin
        for (int i = 0; i < srca_pkg::ENTRY_COUNT; i++)
        begin
            shadow_tag[i] = '0;
            shadow_entry[i] = '0;
        end
        hot_index[0] = '0;
        hot_index[1] = '1;
        for (int i = 2; i < HOT_SLOTS; i++)
            hot_index[i] = slot_t'($urandom);
        hot_tag[0] = '0;
        hot_tag[1] = '1;
        hot_tag[2] = $urandom;
        hot_tag[3] = $urandom;
        send_idle_pct = 37;
        recv_idle_pct = 72;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_entries();
        test_bounds_and_replacement();
        test_age_change();
        // Receiver stalls more than the sender idles, then the reverse,
        // then both run flat out.
        test_random_traffic(8'd255, 37, 72);
        test_random_traffic(8'd0, 37, 72);
        test_random_traffic(8'($urandom_range(255)), 72, 37);
        test_random_traffic(8'd1, 72, 37);
        test_random_traffic(8'd128, 0, 0);
        test_random_traffic(8'($urandom_range(255)), 0, 0);
        test_backpressure();

        if (predicted_replies.size() != 0)
        begin
            $error("%0d owed response beats never arrived", predicted_replies.size());
            fail_count++;
        end
        $display("Run covered %0d probes (%0d tag hits, %0d cutoffs) and %0d stores",
                 probe_count, hit_count, cutoff_count, store_count);
        $display("over %0d search age writes and a %0d-cycle response hold-off.",
                 age_writes, HOLD_CYCLES);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the clearing pass plus the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
